>>> rtl/blx_pkg.sv
// ----------------------------------------------------------------------------
// blx_pkg: shared types and constants for the boolean expression lexer
// Token kinds, character codes and the word layout between the lexer stages.
// ----------------------------------------------------------------------------
package blx_pkg;

    // token kinds as they leave the block
    typedef enum logic [2:0] {
        KIND_IDENT = 3'd0,
        KIND_OR    = 3'd1,
        KIND_NOT   = 3'd2,
        KIND_AND   = 3'd3,
        KIND_OPEN  = 3'd4,
        KIND_CLOSE = 3'd5,
        KIND_END   = 3'd6,
        KIND_ERROR = 3'd7
    } t_kind;

    localparam int unsigned TEXT_W = 60;
    localparam int unsigned LEN_W  = 4;
    localparam int unsigned CODE_W = 6;

    // ASCII codes the lexer cares about
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;

    // code offsets for upper and lower case letters
    localparam logic [5:0] CODE_UPPER = 6'd10;
    localparam logic [5:0] CODE_LOWER = 6'd36;

    // one result word
    typedef struct packed {
        t_kind              kind;
        logic [TEXT_W-1:0]  text;
        logic [LEN_W-1:0]   len;
        logic               last;
    } t_token;

    // character class from the decoder
    typedef struct packed {
        logic               alnum;
        logic               digit;
        logic [CODE_W-1:0]  code;
        logic               sym;
        t_kind              sym_kind;
        logic               space;
    } t_chclass;

    // tokens produced by one character, handed to the result queue
    typedef struct packed {
        logic [1:0] count;
        t_token     tok0;
        t_token     tok1;
    } t_push;

endpackage

>>> rtl/blx_classify.sv
// ----------------------------------------------------------------------------
// blx_classify: character decoder
// Sorts one byte into letter/digit (with its 6-bit code), operator symbol,
// space, or anything else.
// ----------------------------------------------------------------------------
module blx_classify
    import blx_pkg::*;
(
    input  logic [7:0] i_ch,
    output t_chclass   o_cls
);

    logic is_digit;
    logic is_upper;
    logic is_lower;

    assign is_digit = (i_ch >= CH_0)  && (i_ch <= CH_9);
    assign is_upper = (i_ch >= CH_UA) && (i_ch <= CH_UZ);
    assign is_lower = (i_ch >= CH_LA) && (i_ch <= CH_LZ);

    // code and symbol decode
    always_comb begin
        o_cls          = '0;
        o_cls.alnum    = is_digit || is_upper || is_lower;
        o_cls.digit    = is_digit;
        o_cls.sym_kind = KIND_ERROR;
        if (is_digit) begin
            o_cls.code = 6'(i_ch - CH_0);
        end else if (is_upper) begin
            o_cls.code = 6'(i_ch - CH_UA) + CODE_UPPER;
        end else if (is_lower) begin
            o_cls.code = 6'(i_ch - CH_LA) + CODE_LOWER;
        end
        unique case (i_ch)
            CH_PLUS: begin
                o_cls.sym      = 1'b1;
                o_cls.sym_kind = KIND_OR;
            end
            CH_MINUS: begin
                o_cls.sym      = 1'b1;
                o_cls.sym_kind = KIND_NOT;
            end
            CH_STAR: begin
                o_cls.sym      = 1'b1;
                o_cls.sym_kind = KIND_AND;
            end
            CH_OPEN: begin
                o_cls.sym      = 1'b1;
                o_cls.sym_kind = KIND_OPEN;
            end
            CH_CLOSE: begin
                o_cls.sym      = 1'b1;
                o_cls.sym_kind = KIND_CLOSE;
            end
            CH_NL: begin
                o_cls.sym      = 1'b1;
                o_cls.sym_kind = KIND_END;
            end
            CH_SPACE: begin
                o_cls.space = 1'b1;
            end
            default: begin
                o_cls.sym = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/blx_core.sv
// ----------------------------------------------------------------------------
// blx_core: lexer state and token generation
// Holds the input character register, the pending identifier and the halt
// flag, and turns each character into zero, one or two tokens.
// ----------------------------------------------------------------------------
module blx_core
    import blx_pkg::*;
#(
    parameter int MAX_IDENT_LEN = 10
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_ch,
    input  logic [1:0] i_free,
    output t_push      o_push
);

    localparam logic [LEN_W-1:0] LenMax = LEN_W'(MAX_IDENT_LEN);

    logic                 r_in_valid;
    logic [7:0]           r_in_ch;
    logic [LEN_W-1:0]     r_len;
    logic [TEXT_W-1:0]    r_buf;
    logic                 r_halted;

    logic [LEN_W-1:0]     n_len;
    logic [TEXT_W-1:0]    n_buf;
    logic                 n_halted;

    t_chclass             cls;
    t_token               tok0;
    t_token               tok1;
    t_token               tok_sym;
    logic [1:0]           tok_cnt;
    logic                 consume;

    blx_classify u_classify (
        .i_ch  (r_in_ch),
        .o_cls (cls)
    );

    // token generation for the registered character
    always_comb begin
        tok0     = '0;
        tok1     = '0;
        tok_sym  = '0;
        tok_cnt  = 2'd0;
        n_len    = r_len;
        n_buf    = r_buf;
        n_halted = r_halted;
        if (!r_halted) begin
            if (cls.alnum) begin
                if ((r_len == '0) && cls.digit) begin
                    // identifier cannot open with a digit
                    tok0.kind = KIND_ERROR;
                    tok_cnt   = 2'd1;
                    n_halted  = 1'b1;
                end else begin
                    for (int i = 0; i < MAX_IDENT_LEN; i++) begin
                        if (r_len == LEN_W'(i)) begin
                            n_buf[CODE_W*i +: CODE_W] = cls.code;
                        end
                    end
                    if (r_len <= LenMax) begin
                        n_len = r_len + 1'b1;
                    end
                end
            end else if (r_len > LenMax) begin
                // overlong identifier closed by a delimiter
                tok0.kind = KIND_ERROR;
                tok_cnt   = 2'd1;
                n_halted  = 1'b1;
            end else begin
                if (cls.sym) begin
                    tok_sym.kind = cls.sym_kind;
                end else begin
                    tok_sym.kind = KIND_ERROR;
                end
                if (r_len != '0) begin
                    tok0.kind = KIND_IDENT;
                    tok0.text = r_buf;
                    tok0.len  = r_len;
                    n_len     = '0;
                    n_buf     = '0;
                    if (!cls.space) begin
                        tok1    = tok_sym;
                        tok_cnt = 2'd2;
                    end else begin
                        tok_cnt = 2'd1;
                    end
                end else if (!cls.space) begin
                    tok0    = tok_sym;
                    tok_cnt = 2'd1;
                end
                if (!cls.sym && !cls.space) begin
                    n_halted = 1'b1;
                end
            end
        end
        // mark the final token of this character
        if (tok_cnt == 2'd1) begin
            tok0.last = 1'b1;
        end else if (tok_cnt == 2'd2) begin
            tok1.last = 1'b1;
        end
    end

    // the character is retired once the queue has room for all its tokens
    assign consume = r_in_valid && (tok_cnt <= i_free);
    assign o_ready = !r_in_valid || consume;

    always_comb begin
        o_push       = '0;
        o_push.tok0  = tok0;
        o_push.tok1  = tok1;
        o_push.count = consume ? tok_cnt : 2'd0;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_len      <= '0;
            r_buf      <= '0;
            r_halted   <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_in_valid <= 1'b1;
            end else if (consume) begin
                r_in_valid <= 1'b0;
            end
            if (consume) begin
                r_len    <= n_len;
                r_buf    <= n_buf;
                r_halted <= n_halted;
            end
        end
    end

    // input character register
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_ch <= i_ch;
        end
    end

`ifndef ASSERT_OFF
    // once halted, the lexer stays halted until reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt flag dropped without reset");

    // a halted lexer emits nothing
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> (o_push.count == 2'd0))
        else $error("token emitted while halted");

    // pending length never exceeds the saturation value
    a_len_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LenMax + 1'b1)
        else $error("identifier length past saturation");
`endif

endmodule

>>> rtl/blx_outq.sv
// ----------------------------------------------------------------------------
// blx_outq: two-word result queue
// Holds the result register and one spare slot so that a delimiter can
// emit an identifier and its own token from a single character.
// ----------------------------------------------------------------------------
module blx_outq
    import blx_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_push      i_push,
    output logic [1:0] o_free,
    output logic       o_valid,
    input  logic       i_ready,
    output t_token     o_tok
);

    localparam logic [1:0] Depth = 2'd2;

    t_token     r_q [2];
    logic [1:0] r_cnt;

    t_token     n_q [2];
    logic [1:0] n_cnt;
    logic [1:0] base;
    logic       pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_tok   = r_q[0];
    assign o_free  = Depth - r_cnt;

    // shift out the head, then append the new tokens
    always_comb begin
        n_q[0] = r_q[0];
        n_q[1] = r_q[1];
        if (pop) begin
            n_q[0] = r_q[1];
        end
        base = r_cnt - {1'b0, pop};
        if (i_push.count != 2'd0) begin
            if (base == 2'd0) begin
                n_q[0] = i_push.tok0;
            end else begin
                n_q[1] = i_push.tok0;
            end
        end
        if (i_push.count == 2'd2) begin
            n_q[1] = i_push.tok1;
        end
        n_cnt = base + i_push.count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q[0] <= n_q[0];
        r_q[1] <= n_q[1];
    end

`ifndef ASSERT_OFF
    // never push more words than there is room for
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.count <= o_free)
        else $error("result queue overflow");

    // fill level stays within the depth
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= Depth)
        else $error("result queue count out of range");
`endif

endmodule

>>> rtl/boolean_expression_lexer_unit.sv
// ----------------------------------------------------------------------------
// boolean_expression_lexer_unit: boolean expression tokenizer
// Takes one ASCII character per word and emits identifier, operator,
// bracket, end and error tokens.
//
//   channel   dir  tdata                          tlast
//   s_axis    in   [7:0] ch                       -
//   m_axis    out  [2:0] kind, [62:3] text,       last token of the character
//                  [66:63] len, [71:67] zero
//
// One character per cycle while the result queue has room for its tokens;
// a character in the input register is decoded combinationally and its
// tokens are written to the result queue, whose head drives m_axis.
// A delimiter that closes an identifier gives two tokens and needs both
// queue slots free; with the sink always ready each such character can
// still stall the input, either itself or the next token-producing character.
// Synchronous active-low reset clears the identifier and the halt flag.
// Either side may stall at any time; nothing is dropped.
// ----------------------------------------------------------------------------
module boolean_expression_lexer_unit
    import blx_pkg::*;
#(
    parameter int MAX_IDENT_LEN = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [2:0] kind, [62:3] text, [66:63] len
    output logic        m_axis_tlast
);

    t_push      push;
    logic [1:0] free;
    t_token     tok;

    blx_core #(
        .MAX_IDENT_LEN (MAX_IDENT_LEN)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_ch    (s_axis_tdata),
        .i_free  (free),
        .o_push  (push)
    );

    blx_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_free  (free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_tok   (tok)
    );

    // output word packing
    assign m_axis_tdata = {5'b0, tok.len, tok.text, tok.kind};
    assign m_axis_tlast = tok.last;

endmodule
